>>> design/spfm_pkg.sv
// shared constants, types and state codes for the swap page frame mapper
// used by spfm_ctrl and swap_page_frame_mapper; no dependencies
`default_nettype none

package spfm_pkg;

   localparam int FRAMES      = 64;
   localparam int PAGE_BITS   = 12;
   localparam int FRAME_W     = $clog2(FRAMES);
   localparam int TAG_W       = 15;
   localparam int ADDR_W      = 27;
   localparam int FRAME_OUT_W = 6;
   localparam int COFS_W      = 18;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } spfm_state_type;

   typedef struct packed {
      logic [FRAME_W-1:0]   frame;
      logic [PAGE_BITS-1:0] offset;
      logic                 miss;
      logic                 write_back;
      logic [TAG_W-1:0]     evicted_page;
      logic [TAG_W-1:0]     fetch_page;
   } spfm_result_type;

endpackage

`default_nettype wire

>>> design/spfm_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module spfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/spfm_ctrl.sv
// sequencer: last-hit shortcut, serial tag scan, victim choice, frame flags
// depends on spfm_pkg; drives the tag ram of the top level
`default_nettype none

module spfm_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic                                  is_write,
   input  wire logic [spfm_pkg::ADDR_W-1:0]           address,
   output      logic                                  busy,
   output      logic                                  res_valid,
   output      spfm_pkg::spfm_result_type             res,
   output      logic [spfm_pkg::FRAME_W-1:0]          ram_rd_addr,
   input  wire logic [spfm_pkg::TAG_W-1:0]            ram_rd_data,
   output      logic                                  ram_wr_en,
   output      logic [spfm_pkg::FRAME_W-1:0]          ram_wr_addr,
   output      logic [spfm_pkg::TAG_W-1:0]            ram_wr_data
);

   localparam int FW = spfm_pkg::FRAME_W;
   localparam int TW = spfm_pkg::TAG_W;
   localparam int PB = spfm_pkg::PAGE_BITS;
   localparam logic [FW-1:0] LAST_FRAME = FW'(spfm_pkg::FRAMES - 1);
   localparam logic [FW-1:0] FIRST_FRAME = FW'(1);

   spfm_pkg::spfm_state_type state_ff, state_in;
   logic [TW-1:0]            page_ff, page_in;
   logic [PB-1:0]            offs_ff, offs_in;
   logic                     wr_ff, wr_in;
   logic [FW-1:0]            idx_ff, idx_in;
   logic [FW-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                     pend_ff, pend_in;
   logic [TW-1:0]            victim_tag_ff, victim_tag_in;
   logic [FW-1:0]            rptr_ff, rptr_in;
   logic [TW-1:0]            recent_page_ff, recent_page_in;
   logic [FW-1:0]            recent_frame_ff, recent_frame_in;
   logic                     recent_valid_ff, recent_valid_in;
   logic [spfm_pkg::FRAMES-1:0] valid_ff, valid_in;
   logic [spfm_pkg::FRAMES-1:0] dirty_ff, dirty_in;

   logic [TW-1:0]               req_page;
   logic [TW-1:0]               cur_page;
   logic [PB-1:0]               cur_offs;
   logic                        cur_wr;
   logic                        done;
   logic                        miss;
   logic [FW-1:0]               fr;
   logic                        scan_hit;
   logic                        scan_last;
   logic                        victim_seen;
   logic                        wb;

   assign req_page = address[PB +: TW];

   assign scan_hit  = (state_ff == spfm_pkg::ST_SCAN) && pend_ff &&
                      valid_ff[cmp_idx_ff] && (ram_rd_data == page_ff);
   assign scan_last = (state_ff == spfm_pkg::ST_SCAN) && pend_ff &&
                      (cmp_idx_ff == LAST_FRAME);

   // victim tag is picked up as the scan passes the replacement frame
   assign victim_seen   = (state_ff == spfm_pkg::ST_SCAN) && pend_ff &&
                          (cmp_idx_ff == rptr_ff);
   assign victim_tag_in = victim_seen ? ram_rd_data : victim_tag_ff;

   always_comb begin
      state_in   = state_ff;
      page_in    = page_ff;
      offs_in    = offs_ff;
      wr_in      = wr_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in    = pend_ff;
      cur_page   = page_ff;
      cur_offs   = offs_ff;
      cur_wr     = wr_ff;
      done       = 1'b0;
      miss       = 1'b0;
      fr         = rptr_ff;
      case (state_ff)
         spfm_pkg::ST_IDLE: begin
            cur_page = req_page;
            cur_offs = address[PB-1:0];
            cur_wr   = is_write;
            if (start) begin
               if (recent_valid_ff && (recent_page_ff == req_page)) begin
                  done = 1'b1;
                  fr   = recent_frame_ff;
               end else begin
                  state_in = spfm_pkg::ST_SCAN;
                  page_in  = req_page;
                  offs_in  = address[PB-1:0];
                  wr_in    = is_write;
                  idx_in   = FIRST_FRAME;
                  pend_in  = 1'b0;
               end
            end
         end
         spfm_pkg::ST_SCAN: begin
            pend_in    = 1'b1;
            idx_in     = idx_ff + FW'(1);
            cmp_idx_in = idx_ff;
            if (scan_hit) begin
               done     = 1'b1;
               fr       = cmp_idx_ff;
               state_in = spfm_pkg::ST_IDLE;
            end else if (scan_last) begin
               done     = 1'b1;
               miss     = 1'b1;
               state_in = spfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spfm_pkg::ST_IDLE;
         end
      endcase
   end

   assign wb = miss && valid_ff[fr] && dirty_ff[fr];

   always_comb begin
      valid_in        = valid_ff;
      dirty_in        = dirty_ff;
      rptr_in         = rptr_ff;
      recent_page_in  = recent_page_ff;
      recent_frame_in = recent_frame_ff;
      recent_valid_in = recent_valid_ff;
      if (done) begin
         recent_page_in  = cur_page;
         recent_frame_in = fr;
         recent_valid_in = 1'b1;
         if (miss) begin
            valid_in[fr] = 1'b1;
            dirty_in[fr] = cur_wr;
            rptr_in      = (rptr_ff == LAST_FRAME) ? FIRST_FRAME : rptr_ff + FW'(1);
         end else if (cur_wr) begin
            dirty_in[fr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= spfm_pkg::ST_IDLE;
         pend_ff         <= 1'b0;
         rptr_ff         <= FIRST_FRAME;
         recent_valid_ff <= 1'b0;
         recent_page_ff  <= '0;
         recent_frame_ff <= '0;
         valid_ff        <= '0;
         dirty_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         pend_ff         <= pend_in;
         rptr_ff         <= rptr_in;
         recent_valid_ff <= recent_valid_in;
         recent_page_ff  <= recent_page_in;
         recent_frame_ff <= recent_frame_in;
         valid_ff        <= valid_in;
         dirty_ff        <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      offs_ff       <= offs_in;
      wr_ff         <= wr_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      victim_tag_ff <= victim_tag_in;
   end

   assign busy        = (state_ff != spfm_pkg::ST_IDLE);
   assign ram_rd_addr = (idx_ff <= LAST_FRAME) ? idx_ff : '0;
   assign ram_wr_en   = done && miss;
   assign ram_wr_addr = fr;
   assign ram_wr_data = cur_page;

   assign res_valid        = done;
   assign res.frame        = fr;
   assign res.offset       = cur_offs;
   assign res.miss         = miss;
   assign res.write_back   = wb;
   assign res.evicted_page = wb ? victim_tag_in : '0;
   assign res.fetch_page   = miss ? cur_page : '0;

`ifndef ASSERT_OFF
   a_rptr_range: assert property (@(posedge clock) disable iff (reset)
      (rptr_ff != '0) && (rptr_ff <= LAST_FRAME))
      else $error("replacement pointer left frames 1 to last");
   a_scan_skips_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spfm_pkg::ST_SCAN && pend_ff) |-> (cmp_idx_ff != '0))
      else $error("scan compared frame zero");
   a_miss_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (done && miss) |=> valid_ff[$past(fr)] && recent_valid_ff)
      else $error("filled frame not marked valid");
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !done) |=> (state_ff == spfm_pkg::ST_SCAN) && !pend_ff)
      else $error("request without shortcut hit did not start a scan");
`endif

endmodule

`default_nettype wire

>>> design/swap_page_frame_mapper.sv
// top level: page frame mapper with serial tag scan and registered result
// depends on spfm_pkg, spfm_ram and spfm_ctrl
//
// channel   ports                                  handshake
// request   req_is_write, req_address              start high while busy low
// response  rsp_frame .. rsp_fetch_page            rsp_valid, one cycle
//
// a request that hits the last-hit page resolves in the request cycle, busy stays low
// a hit found in frame j ends the scan at frame j
// a miss scans every tag in the ram but frame zero, one a cycle
// the response strobes in the cycle after the request resolves
// reset clears valid and dirty flags at once; tag ram needs no clearing pass
`default_nettype none

module swap_page_frame_mapper (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic                                req_is_write,
   input  wire logic [spfm_pkg::ADDR_W-1:0]         req_address,
   output      logic                                rsp_valid,
   output      logic [spfm_pkg::FRAME_OUT_W-1:0]    rsp_frame,
   output      logic [spfm_pkg::COFS_W-1:0]         rsp_cache_offset,
   output      logic                                rsp_miss,
   output      logic                                rsp_write_back,
   output      logic [spfm_pkg::TAG_W-1:0]          rsp_evicted_page,
   output      logic [spfm_pkg::TAG_W-1:0]          rsp_fetch_page
);

   spfm_pkg::spfm_result_type           res;
   logic                                res_valid;
   logic [spfm_pkg::FRAME_W-1:0]        ram_rd_addr;
   logic [spfm_pkg::TAG_W-1:0]          ram_rd_data;
   logic                                ram_wr_en;
   logic [spfm_pkg::FRAME_W-1:0]        ram_wr_addr;
   logic [spfm_pkg::TAG_W-1:0]          ram_wr_data;

   logic                                rsp_valid_ff;
   logic [spfm_pkg::FRAME_OUT_W-1:0]    rsp_frame_ff;
   logic [spfm_pkg::COFS_W-1:0]         rsp_cache_offset_ff;
   logic                                rsp_miss_ff;
   logic                                rsp_write_back_ff;
   logic [spfm_pkg::TAG_W-1:0]          rsp_evicted_page_ff;
   logic [spfm_pkg::TAG_W-1:0]          rsp_fetch_page_ff;

   spfm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .is_write    (req_is_write),
      .address     (req_address),
      .busy        (busy),
      .res_valid   (res_valid),
      .res         (res),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   spfm_ram #(
      .WIDTH (spfm_pkg::TAG_W),
      .DEPTH (spfm_pkg::FRAMES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_frame_ff        <= spfm_pkg::FRAME_OUT_W'(res.frame);
         rsp_cache_offset_ff <= spfm_pkg::COFS_W'({res.frame, res.offset});
         rsp_miss_ff         <= res.miss;
         rsp_write_back_ff   <= res.write_back;
         rsp_evicted_page_ff <= res.evicted_page;
         rsp_fetch_page_ff   <= res.fetch_page;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_cache_offset = rsp_cache_offset_ff;
   assign rsp_miss         = rsp_miss_ff;
   assign rsp_write_back   = rsp_write_back_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fetch_page   = rsp_fetch_page_ff;

endmodule

`default_nettype wire
